>>> rtl/glyph_shelf_packer_defines.svh
// assertion macros shared by the checker
`ifndef GLYPH_SHELF_PACKER_DEFINES_SVH
`define GLYPH_SHELF_PACKER_DEFINES_SVH

// property must hold once out of reset
`define GSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define GSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/gsp_pkg.sv
// shared types and constants of the glyph shelf packer
`default_nettype none
package gsp_pkg;
   localparam logic [3:0] ST_PLACED        = 4'd0;
   localparam logic [3:0] ST_EMPTY         = 4'd1;
   localparam logic [3:0] ST_NO_OWNER      = 4'd2;
   localparam logic [3:0] ST_EMPTY_PAYLOAD = 4'd3;
   localparam logic [3:0] ST_BAD_ENC       = 4'd4;
   localparam logic [3:0] ST_MISFIT        = 4'd5;
   localparam logic [3:0] ST_BUDGET        = 4'd6;
   localparam logic [3:0] ST_TABLE_FULL    = 4'd7;
   localparam logic [3:0] ST_FAILED        = 4'd8;

   localparam logic CSR_PAGE_SIZE = 1'b0;
   localparam logic CSR_MAX_PAGES = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture item and run checks
      logic key_clear;   // reset key scan pointer
      logic key_step;    // examine one key entry
      logic page_clear;  // reset page scan pointer
      logic page_step;   // examine one page
      logic commit;      // write page and key state
      logic finish;      // load result register
      logic set_fail;    // latch layout failure
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       failed;     // layout already failed (after optional clear)
      logic [3:0] chk_status; // validation status, ST_PLACED if clean
      logic       key_done;
      logic       key_hit;
      logic       key_free;
      logic       page_done;
      logic       page_found;
      logic       can_open;
   } sts_type;
endpackage
`default_nettype wire

>>> rtl/glyph_shelf_packer.sv
// Glyph shelf packer: each item is first checked, then the key table is scanned (a memory
// read one entry per cycle), then the open pages are tried one per cycle; items that fail
// the checks skip both scans. The result sits in an output register; a new item is taken
// once the previous result has been loaded into that register.
`default_nettype none
module glyph_shelf_packer #(
   parameter int MAX_PAGES   = 16,
   parameter int KEY_ENTRIES = 64,
   parameter int PAGE_LIMIT  = 4096,
   parameter int KEY_BITS    = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire [12:0]  csr_data,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_first_of_layout,
   input  wire         req_glyph_present,
   input  wire [31:0]  req_glyph_key,
   input  wire [12:0]  req_glyph_width,
   input  wire [12:0]  req_glyph_height,
   input  wire [1:0]   req_pixel_encoding,
   input  wire [25:0]  req_payload_bytes,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [3:0]  rsp_page_index,
   output logic [11:0] rsp_pos_x,
   output logic [11:0] rsp_pos_y,
   output logic        rsp_fresh_place,
   output logic        rsp_opened_page
);
   import gsp_pkg::*;

   logic [12:0] page_size_ff;
   logic [4:0]  max_pages_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic [3:0]  fin_status;
   logic        fin_place;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= 13'd1024;
         max_pages_ff <= 5'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGE_SIZE: page_size_ff <= csr_data;
            CSR_MAX_PAGES: max_pages_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   gsp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .out_full(rsp_valid && !rsp_ready), .sts(sts), .cmd(cmd),
      .fin_status(fin_status), .fin_place(fin_place)
   );

   gsp_datapath #(
      .MAX_PAGES(MAX_PAGES), .KEY_ENTRIES(KEY_ENTRIES),
      .PAGE_LIMIT(PAGE_LIMIT), .KEY_BITS(KEY_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .fin_status(fin_status), .fin_place(fin_place),
      .page_size(page_size_ff), .max_pages(max_pages_ff),
      .req_first_of_layout(req_first_of_layout), .req_glyph_present(req_glyph_present),
      .req_glyph_key(req_glyph_key), .req_glyph_width(req_glyph_width),
      .req_glyph_height(req_glyph_height), .req_pixel_encoding(req_pixel_encoding),
      .req_payload_bytes(req_payload_bytes),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_page_index(rsp_page_index), .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_fresh_place(rsp_fresh_place), .rsp_opened_page(rsp_opened_page)
   );
endmodule
`default_nettype wire

>>> rtl/gsp_ctrl.sv
// controller state machine of the glyph shelf packer
`default_nettype none
module gsp_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire              out_full,
   input  wire gsp_pkg::sts_type sts,
   output gsp_pkg::cmd_type cmd,
   output logic [3:0]       fin_status,
   output logic             fin_place
);
   import gsp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_KEY   = 3'd2;
   localparam logic [2:0] S_PAGE  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] res_status_ff, res_status_in;
   logic       res_place_ff, res_place_in;

   assign req_ready = (state_ff == S_IDLE);
   assign fin_status = res_status_ff;
   assign fin_place = res_place_ff;

   always_comb begin
      state_in = state_ff;
      res_status_in = res_status_ff;
      res_place_in = res_place_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_place_in = 1'b0;
            if (sts.failed) begin
               res_status_in = ST_FAILED;
               state_in = S_DONE;
            end else if (sts.chk_status != ST_PLACED) begin
               res_status_in = sts.chk_status;
               cmd.set_fail = (sts.chk_status != ST_EMPTY);
               state_in = S_DONE;
            end else begin
               cmd.key_clear = 1'b1;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            if (sts.key_hit) begin
               res_status_in = ST_PLACED;
               res_place_in = 1'b0;
               state_in = S_DONE;
            end else if (sts.key_done) begin
               if (!sts.key_free) begin
                  res_status_in = ST_TABLE_FULL;
                  cmd.set_fail = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.page_clear = 1'b1;
                  state_in = S_PAGE;
               end
            end else begin
               cmd.key_step = 1'b1;
            end
         end
         S_PAGE: begin
            if (sts.page_found) begin
               cmd.commit = 1'b1;
               res_status_in = ST_PLACED;
               res_place_in = 1'b1;
               state_in = S_DONE;
            end else if (sts.page_done) begin
               if (sts.can_open) begin
                  cmd.commit = 1'b1;
                  res_status_in = ST_PLACED;
                  res_place_in = 1'b1;
               end else begin
                  res_status_in = ST_BUDGET;
                  cmd.set_fail = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               cmd.page_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!out_full) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      res_status_ff <= res_status_in;
      res_place_ff <= res_place_in;
   end
endmodule
`default_nettype wire

>>> rtl/gsp_datapath.sv
// datapath: item checks, key table scan, page scan and page state
`default_nettype none
module gsp_datapath #(
   parameter int MAX_PAGES   = 16,
   parameter int KEY_ENTRIES = 64,
   parameter int PAGE_LIMIT  = 4096,
   parameter int KEY_BITS    = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  wire gsp_pkg::cmd_type cmd,
   output gsp_pkg::sts_type sts,
   input  wire [3:0]        fin_status,
   input  wire              fin_place,
   input  wire [12:0]       page_size,
   input  wire [4:0]        max_pages,
   input  wire              req_first_of_layout,
   input  wire              req_glyph_present,
   input  wire [31:0]       req_glyph_key,
   input  wire [12:0]       req_glyph_width,
   input  wire [12:0]       req_glyph_height,
   input  wire [1:0]        req_pixel_encoding,
   input  wire [25:0]       req_payload_bytes,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output logic [3:0]       rsp_status,
   output logic [3:0]       rsp_page_index,
   output logic [11:0]      rsp_pos_x,
   output logic [11:0]      rsp_pos_y,
   output logic             rsp_fresh_place,
   output logic             rsp_opened_page
);
   import gsp_pkg::*;

   localparam int PW = $clog2(MAX_PAGES + 1);
   localparam int PI = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int KI = $clog2(KEY_ENTRIES);
   localparam int KC = $clog2(KEY_ENTRIES + 1);
   localparam int SW = $clog2(PAGE_LIMIT + 1) + 1;
   localparam logic [SW-1:0] PS_MAX = SW'(PAGE_LIMIT);
   localparam logic [PW-1:0] PAGES_CAP = PW'(MAX_PAGES);

   // captured item
   logic [12:0] w_ff, h_ff;
   logic        enc_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [SW-1:0] ps_ff;
   logic [3:0]  chk_ff;

   // layout state
   logic          failed_ff;
   logic [PW-1:0] page_count_ff;
   logic [MAX_PAGES-1:0] page_enc_ff;
   logic [12:0]   cur_x_ff [MAX_PAGES];
   logic [12:0]   cur_y_ff [MAX_PAGES];
   logic [11:0]   row_h_ff [MAX_PAGES];
   logic [KEY_ENTRIES-1:0] key_used_ff;
   logic [KEY_BITS-1:0] key_mem [KEY_ENTRIES];
   logic [27:0]   place_mem [KEY_ENTRIES];

   // scans
   logic [KC-1:0] kptr_ff;
   logic          khit_ff, kfree_ff, kvalid_ff;
   logic [KI-1:0] kslot_ff;
   logic [KEY_BITS-1:0] krd_ff;
   logic [27:0]   prd_ff;
   logic [PW-1:0] pptr_ff;
   logic          pfound_ff;
   logic [PI-1:0] psel_ff;
   logic [12:0]   px_ff, py_ff;
   logic [11:0]   prh_ff;
   logic [27:0]   hit_place_ff;

   // result register
   logic        rv_ff;
   logic [3:0]  rs_ff, rp_ff;
   logic [11:0] rx_ff, ry_ff;
   logic        rf_ff, ro_ff;

   // validation of the incoming item
   logic [SW-1:0] ps_sat;
   logic [4:0]    lim_sat;
   logic [3:0]    chk;
   logic [27:0]   area;
   logic [27:0]   need;
   always_comb begin
      ps_sat = SW'(page_size);
      if (ps_sat < SW'(4)) ps_sat = SW'(4);
      if (ps_sat > PS_MAX) ps_sat = PS_MAX;
      lim_sat = max_pages;
      area = 28'(req_glyph_width) * 28'(req_glyph_height);
      need = req_pixel_encoding[0] ? {area[25:0], 2'b00} : area;
      if (!req_glyph_present) chk = ST_NO_OWNER;
      else if (req_glyph_width == '0 || req_glyph_height == '0)
         chk = (req_payload_bytes != '0) ? ST_EMPTY_PAYLOAD : ST_EMPTY;
      else if (req_pixel_encoding[1]) chk = ST_BAD_ENC;
      else if (SW'(req_glyph_width) > ps_sat - SW'(2) ||
               SW'(req_glyph_height) > ps_sat - SW'(2) ||
               need != 28'(req_payload_bytes))
         chk = ST_MISFIT;
      else chk = ST_PLACED;
   end

   logic [PW-1:0] lim_eff;
   assign lim_eff = (PW'(lim_sat) > PAGES_CAP || 32'(lim_sat) > MAX_PAGES) ?
                    PAGES_CAP : PW'(lim_sat);

   // page candidate at scan pointer
   logic [PI-1:0] pidx;
   logic [SW:0]   cx, cy, rh;
   logic          pfit, pmatch;
   assign pidx = pptr_ff[PI-1:0];
   always_comb begin
      cx = (SW+1)'(cur_x_ff[pidx]);
      cy = (SW+1)'(cur_y_ff[pidx]);
      rh = (SW+1)'(row_h_ff[pidx]);
      if (cx + (SW+1)'(w_ff) + 1'b1 > (SW+1)'(ps_ff)) begin
         cx = (SW+1)'(1);
         cy = cy + rh + 1'b1;
         rh = '0;
      end
      pmatch = (page_enc_ff[pidx] == enc_ff) && (pptr_ff < page_count_ff);
      pfit = pmatch && (cy + (SW+1)'(h_ff) + 1'b1 <= (SW+1)'(ps_ff));
   end

   logic [KI-1:0] kidx;
   assign kidx = kptr_ff[KI-1:0];

   assign sts.failed = failed_ff;
   assign sts.chk_status = chk_ff;
   assign sts.key_done = (kptr_ff == KC'(KEY_ENTRIES)) && !kvalid_ff;
   assign sts.key_hit = kvalid_ff && key_used_ff[kslot_ff] && (krd_ff == key_ff);
   assign sts.key_free = kfree_ff;
   assign sts.page_done = (pptr_ff >= page_count_ff) || (32'(pptr_ff) >= MAX_PAGES);
   assign sts.page_found = pfound_ff;
   assign sts.can_open = (page_count_ff < lim_eff) && (32'(page_count_ff) < MAX_PAGES);

   // final placement
   logic [PI-1:0] sel;
   logic [12:0]   fx, fy;
   logic [11:0]   frh;
   logic [27:0]   new_place;
   logic [KI-1:0] kept_slot;
   always_comb begin
      if (pfound_ff) begin
         sel = psel_ff; fx = px_ff; fy = py_ff; frh = prh_ff;
      end else begin
         sel = page_count_ff[PI-1:0]; fx = 13'd1; fy = 13'd1; frh = '0;
      end
      new_place = {4'(sel), fx[11:0], fy[11:0]};
   end

   always_ff @(posedge clock) begin
      krd_ff <= key_mem[kidx];
      prd_ff <= place_mem[kidx];
      if (cmd.commit) begin
         key_mem[kept_slot] <= key_ff;
         place_mem[kept_slot] <= new_place;
      end
   end
   assign kept_slot = kslot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff <= 1'b0;
         page_count_ff <= '0;
         key_used_ff <= '0;
         rv_ff <= 1'b0;
         kvalid_ff <= 1'b0;
         pfound_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            w_ff <= req_glyph_width;
            h_ff <= req_glyph_height;
            enc_ff <= req_pixel_encoding[0];
            key_ff <= KEY_BITS'(req_glyph_key);
            ps_ff <= ps_sat;
            chk_ff <= chk;
            if (req_first_of_layout) begin
               failed_ff <= 1'b0;
               page_count_ff <= '0;
               key_used_ff <= '0;
            end
         end
         if (cmd.set_fail) failed_ff <= 1'b1;
         if (cmd.key_clear) begin
            kptr_ff <= '0;
            kvalid_ff <= 1'b0;
            kfree_ff <= 1'b0;
            khit_ff <= 1'b0;
         end
         if (cmd.key_step) begin
            // one entry read per cycle, compared on the following cycle
            if (kvalid_ff && !key_used_ff[kslot_ff] && !kfree_ff) begin
               kfree_ff <= 1'b1;
            end
            if (kptr_ff != KC'(KEY_ENTRIES)) begin
               kslot_ff <= (kvalid_ff && !key_used_ff[kslot_ff] && !kfree_ff) ?
                           kslot_ff : kidx;
               kvalid_ff <= 1'b1;
               kptr_ff <= kptr_ff + 1'b1;
            end else begin
               kvalid_ff <= 1'b0;
            end
            if (kfree_ff || (kvalid_ff && !key_used_ff[kslot_ff])) begin
               kslot_ff <= kslot_ff;
               if (kptr_ff != KC'(KEY_ENTRIES)) kvalid_ff <= 1'b1;
            end
            khit_ff <= 1'b0;
         end
         if (sts.key_hit) hit_place_ff <= prd_ff;
         if (cmd.page_clear) begin
            pptr_ff <= '0;
            pfound_ff <= 1'b0;
         end
         if (cmd.page_step) begin
            if (pfit) begin
               pfound_ff <= 1'b1;
               psel_ff <= pidx;
               px_ff <= cx[12:0];
               py_ff <= cy[12:0];
               prh_ff <= rh[11:0];
            end else begin
               pptr_ff <= pptr_ff + 1'b1;
            end
         end
         if (cmd.commit) begin
            if (!pfound_ff) begin
               page_count_ff <= page_count_ff + 1'b1;
               page_enc_ff[sel] <= enc_ff;
            end
            cur_x_ff[sel] <= fx + w_ff + 13'd1;
            cur_y_ff[sel] <= fy;
            row_h_ff[sel] <= (frh > h_ff[11:0]) ? frh : h_ff[11:0];
            key_used_ff[kept_slot] <= 1'b1;
            hit_place_ff <= new_place;
            ro_ff <= !pfound_ff;
         end
         if (cmd.finish) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rs_ff <= fin_status;
         if (fin_status == ST_PLACED) begin
            rp_ff <= hit_place_ff[27:24];
            rx_ff <= hit_place_ff[23:12];
            ry_ff <= hit_place_ff[11:0];
            rf_ff <= fin_place;
            ro_ff <= fin_place && ro_ff;
         end else begin
            rp_ff <= '0; rx_ff <= '0; ry_ff <= '0; rf_ff <= 1'b0; ro_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_page_index = rp_ff;
   assign rsp_pos_x = rx_ff;
   assign rsp_pos_y = ry_ff;
   assign rsp_fresh_place = rf_ff;
   assign rsp_opened_page = ro_ff;
endmodule
`default_nettype wire

>>> rtl/gsp_checker.sv
// port-level checks of the glyph shelf packer
`default_nettype none
`include "glyph_shelf_packer_defines.svh"
module gsp_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [3:0]  rsp_status,
   input wire        rsp_fresh_place,
   input wire        rsp_opened_page
);
   `GSP_ASSERT(a_opened_fresh, !rsp_valid || !rsp_opened_page || rsp_fresh_place, "opened without fresh")
   `GSP_ASSERT(a_fresh_placed, !rsp_valid || !rsp_fresh_place || rsp_status == 4'd0, "fresh on error")
   `GSP_ASSERT(a_status_range, !rsp_valid || rsp_status <= 4'd8, "status out of range")
   `GSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped")
endmodule
bind glyph_shelf_packer gsp_checker u_gsp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_fresh_place(rsp_fresh_place), .rsp_opened_page(rsp_opened_page)
);
`default_nettype wire
